/* hw/rtl/vcls_pkg.sv */
package vcls_pkg;

  localparam int CompW   = 16;
  localparam int LimW    = 15;
  localparam int SumW    = 32;
  localparam int MagW    = 16;
  localparam int ProdW   = LimW + CompW;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgHorizLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVertLimit  = 1'b1;

  localparam logic [LimW-1:0] HorizLimitReset = 15'd256;
  localparam logic [LimW-1:0] VertLimitReset  = 15'd256;

  localparam int QueueDepth = 4;

  // scaling mode chosen by the front part
  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_SCALE = 2'd1,
    MODE_VERT  = 2'd2
  } mode_t;

  // classified request handed from front to back
  typedef struct packed {
    mode_t                   mode;
    logic                    en_z;
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic [LimW-1:0]         lim;
    logic [MagW:0]           mag;
  } job_t;

endpackage

/* hw/rtl/vcls_isqrt.sv */
// pipelined integer square root, one result bit per stage
module vcls_isqrt (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [vcls_pkg::SumW-1:0]    rad,
  output logic [vcls_pkg::MagW-1:0]    root
);
  import vcls_pkg::*;

  localparam int Stages = MagW;

  logic [SumW-1:0] rem_r [Stages+1];
  logic [MagW-1:0] res_r [Stages+1];

  always_comb begin
    rem_r[0] = rad;
    res_r[0] = '0;
  end

  // bit Stages-1-k of the root is decided in stage k, msb first
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int B = Stages - 1 - s;
    logic [SumW+1:0] trial;
    logic [SumW-1:0] rem_nxt;
    logic [MagW-1:0] res_nxt;
    logic [SumW-1:0] rem_q;
    logic [MagW-1:0] res_q;
    always_comb begin
      trial = ({2'b00, SumW'(res_r[s])} << (B + 1)) + ({{(SumW+1){1'b0}}, 1'b1} << (2 * B));
      if ({2'b00, rem_r[s]} >= trial) begin
        rem_nxt = rem_r[s] - trial[SumW-1:0];
        res_nxt = res_r[s] | (MagW'(1) << B);
      end else begin
        rem_nxt = rem_r[s];
        res_nxt = res_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q <= rem_nxt;
        res_q <= res_nxt;
      end
    end
    always_comb begin
      rem_r[s+1] = rem_q;
      res_r[s+1] = res_q;
    end
  end

  assign root = res_r[Stages];

endmodule

/* hw/rtl/vcls_front.sv */
// front part: magnitudes, limit choice, classification
module vcls_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [vcls_pkg::CompW-1:0] in_dir_x,
  input  logic signed [vcls_pkg::CompW-1:0] in_dir_y,
  input  logic signed [vcls_pkg::CompW-1:0] in_dir_z,
  input  logic [vcls_pkg::LimW-1:0]         hl,
  input  logic [vcls_pkg::LimW-1:0]         vl,
  output logic                              job_valid,
  output vcls_pkg::job_t                    job
);
  import vcls_pkg::*;

  localparam int Lat = MagW + 1;

  // square sum stage
  logic [SumW-1:0] sq_sum;
  logic [CompW-1:0] ax, ay;
  logic signed [CompW-1:0] xs_r [Lat+1];
  logic signed [CompW-1:0] ys_r [Lat+1];
  logic signed [CompW-1:0] zs_r [Lat+1];
  logic [LimW-1:0] hl_r [Lat+1];
  logic [LimW-1:0] vl_r [Lat+1];
  logic            vld_r [Lat+1];
  logic [SumW-1:0] sq_r;
  logic [MagW-1:0] hmag;

  assign ax = in_dir_x[CompW-1] ? CompW'(-in_dir_x) : in_dir_x;
  assign ay = in_dir_y[CompW-1] ? CompW'(-in_dir_y) : in_dir_y;
  assign sq_sum = SumW'(ax * ax) + SumW'(ay * ay);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r     <= sq_sum;
      xs_r[0]  <= in_dir_x;
      ys_r[0]  <= in_dir_y;
      zs_r[0]  <= in_dir_z;
      hl_r[0]  <= hl;
      vl_r[0]  <= vl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  vcls_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (sq_r),
    .root (hmag)
  );

  // side-band delay line matching the root
  for (genvar i = 0; i < Lat; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        xs_r[i+1] <= xs_r[i];
        ys_r[i+1] <= ys_r[i];
        zs_r[i+1] <= zs_r[i];
        hl_r[i+1] <= hl_r[i];
        vl_r[i+1] <= vl_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  // ratio compare and classification
  logic [CompW:0]   zmag;
  logic signed [CompW-1:0] zc;
  logic [ProdW:0]   lhs, rhs;
  job_t job_nxt;
  logic [ProdW:0] lhs_r, rhs_r;
  logic pre_vld_r;
  logic hz, zz;
  logic [CompW:0] zs_abs_q;
  logic [MagW-1:0] hmag_d;

  assign zc   = zs_r[Lat-1];
  assign zmag = zc[CompW-1] ? (CompW+1)'(-{zc[CompW-1], zc}) : {1'b0, zc};

  // align the root with the delayed side-band
  always_ff @(posedge clk) begin
    if (adv) begin
      zs_abs_q <= zmag;
      hmag_d   <= hmag;
    end
  end

  // pipeline the compare products one stage
  always_ff @(posedge clk) begin
    if (adv) begin
      lhs_r <= (ProdW+1)'(hl_r[Lat] * zs_abs_q);
      rhs_r <= (ProdW+1)'(vl_r[Lat] * hmag_d);
    end
  end

  logic [MagW-1:0] hmag_q;
  logic signed [CompW-1:0] xq, yq, zq;
  logic [LimW-1:0] hlq, vlq;
  logic [CompW:0] zmq;
  always_ff @(posedge clk) begin
    if (adv) begin
      hmag_q <= hmag_d;
      xq     <= xs_r[Lat];
      yq     <= ys_r[Lat];
      zq     <= zs_r[Lat];
      hlq    <= hl_r[Lat];
      vlq    <= vl_r[Lat];
      zmq    <= zs_abs_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (adv) begin
      pre_vld_r <= vld_r[Lat];
    end
  end

  assign hz = (hmag_q != '0);
  assign zz = (zmq != '0);
  assign lhs = lhs_r;
  assign rhs = rhs_r;

  always_comb begin
    job_nxt.x    = xq;
    job_nxt.y    = yq;
    job_nxt.z    = zq;
    job_nxt.en_z = zz;
    job_nxt.mode = MODE_ZERO;
    job_nxt.lim  = hlq;
    job_nxt.mag  = {1'b0, hmag_q};
    if (hz && zz) begin
      job_nxt.mode = MODE_SCALE;
      if (lhs > rhs) begin
        job_nxt.lim = vlq;
        job_nxt.mag = zmq;
      end
    end else if (hz) begin
      job_nxt.mode = MODE_SCALE;
    end else if (zz) begin
      job_nxt.mode = MODE_VERT;
      job_nxt.lim  = vlq;
    end
  end

  assign job_valid = pre_vld_r;
  assign job       = job_nxt;

endmodule

/* hw/rtl/vcls_queue.sv */
// small request fifo between front and back
module vcls_queue #(
  parameter int Depth = vcls_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  vcls_pkg::job_t wr_data,
  input  logic           rd_en,
  output logic           rd_valid,
  output vcls_pkg::job_t rd_data,
  output logic [$clog2(Depth+1)-1:0] count
);
  import vcls_pkg::*;

  localparam int AW = $clog2(Depth);

  job_t            mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [$clog2(Depth+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
    end
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign count    = cnt_r;

endmodule

/* hw/rtl/vcls_back.sv */
// back part: multiply, pipelined divide, saturate
module vcls_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               job_valid,
  input  vcls_pkg::job_t                     job,
  output logic                               res_valid,
  output logic signed [vcls_pkg::CompW-1:0]  res_x,
  output logic signed [vcls_pkg::CompW-1:0]  res_y,
  output logic signed [vcls_pkg::CompW-1:0]  res_z,
  output logic                               res_sat
);
  import vcls_pkg::*;

  localparam int NW = ProdW + 1;
  localparam int DW = MagW + 1;

  // lane record through the divider
  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] quo;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic          vld;
    mode_t         mode;
    logic          en_z;
    logic          zneg;
    logic [LimW-1:0] lim;
    logic [DW-1:0] mag;
  } ctl_t;

  lane_t lx_r [NW+1];
  lane_t ly_r [NW+1];
  lane_t lz_r [NW+1];
  ctl_t  c_r  [NW+1];

  // products stage
  logic [CompW:0] ax, ay, az;
  assign ax = job.x[CompW-1] ? (CompW+1)'(-{job.x[CompW-1], job.x}) : {1'b0, job.x};
  assign ay = job.y[CompW-1] ? (CompW+1)'(-{job.y[CompW-1], job.y}) : {1'b0, job.y};
  assign az = job.z[CompW-1] ? (CompW+1)'(-{job.z[CompW-1], job.z}) : {1'b0, job.z};

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r[0] <= '{rem: '0, quo: NW'(ax * job.lim), neg: job.x[CompW-1]};
      ly_r[0] <= '{rem: '0, quo: NW'(ay * job.lim), neg: job.y[CompW-1]};
      lz_r[0] <= '{rem: '0, quo: (job.en_z ? NW'(az * job.lim) : '0),
                   neg: job.z[CompW-1]};
      c_r[0].mode <= job.mode;
      c_r[0].en_z <= job.en_z;
      c_r[0].zneg <= job.z[CompW-1];
      c_r[0].lim  <= job.lim;
      c_r[0].mag  <= job.mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r[0].vld <= 1'b0;
    end else if (adv) begin
      c_r[0].vld <= job_valid;
    end
  end

  // restoring division, one quotient bit per stage
  function automatic lane_t div_step(lane_t l, logic [DW-1:0] d);
    logic [NW:0] r2;
    lane_t o;
    r2 = {l.rem, l.quo[NW-1]};
    o.neg = l.neg;
    o.quo = {l.quo[NW-2:0], 1'b0};
    if (r2 >= (NW+1)'(d)) begin
      r2 = r2 - (NW+1)'(d);
      o.quo[0] = 1'b1;
    end
    o.rem = r2[NW-1:0];
    return o;
  endfunction

  for (genvar s = 0; s < NW; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        lx_r[s+1] <= div_step(lx_r[s], c_r[s].mag);
        ly_r[s+1] <= div_step(ly_r[s], c_r[s].mag);
        lz_r[s+1] <= div_step(lz_r[s], c_r[s].mag);
        c_r[s+1].mode <= c_r[s].mode;
        c_r[s+1].en_z <= c_r[s].en_z;
        c_r[s+1].zneg <= c_r[s].zneg;
        c_r[s+1].lim  <= c_r[s].lim;
        c_r[s+1].mag  <= c_r[s].mag;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[s+1].vld <= 1'b0;
      end else if (adv) begin
        c_r[s+1].vld <= c_r[s].vld;
      end
    end
  end

  // saturation of one lane
  function automatic logic [CompW:0] sat_lane(lane_t l);
    logic [CompW-1:0] v;
    logic s;
    s = 1'b0;
    if (l.neg) begin
      if (l.quo > NW'(32768)) begin
        v = 16'h8000;
        s = 1'b1;
      end else begin
        v = CompW'(-l.quo[CompW-1:0]);
      end
    end else begin
      if (l.quo > NW'(32767)) begin
        v = 16'h7fff;
        s = 1'b1;
      end else begin
        v = l.quo[CompW-1:0];
      end
    end
    return {s, v};
  endfunction

  logic [CompW:0] sx, sy, sz;
  ctl_t ce;
  assign ce = c_r[NW];
  assign sx = sat_lane(lx_r[NW]);
  assign sy = sat_lane(ly_r[NW]);
  assign sz = sat_lane(lz_r[NW]);

  always_comb begin
    res_valid = ce.vld;
    res_x = '0;
    res_y = '0;
    res_z = '0;
    res_sat = 1'b0;
    unique case (ce.mode)
      MODE_SCALE: begin
        res_x = sx[CompW-1:0];
        res_y = sy[CompW-1:0];
        res_z = ce.en_z ? sz[CompW-1:0] : '0;
        res_sat = sx[CompW] | sy[CompW] | (ce.en_z & sz[CompW]);
      end
      MODE_VERT: begin
        res_z = ce.zneg ? CompW'(-{1'b0, ce.lim}) : CompW'({1'b0, ce.lim});
      end
      default: begin
        res_z = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/velocity_command_limit_scaler.sv */
// Velocity command limit scaler. Each request (dir_x, dir_y, dir_z, signed Q7.8)
// is rescaled to the largest vector within the horizontal and vertical speed
// limits; one result per request, in order. One request per cycle sustained
// while in_stall is low. A result passes through the front pipeline (square
// sum, a 16-stage square root, ratio compare), the fifo, and the back pipeline
// (multiply and a 32-stage divider) including the output register, before it
// shows on out_valid. The back part stops only on out_stall; the front keeps
// going until a finished request meets a full 4-entry fifo between them, and
// only then is in_stall raised. The user must write limits through the cfg port
// only while no request is in flight; the block itself does not enforce this.
module velocity_command_limit_scaler #(
  parameter int QDepth = vcls_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vcls_pkg::CompW-1:0] in_dir_x,
  input  logic signed [vcls_pkg::CompW-1:0] in_dir_y,
  input  logic signed [vcls_pkg::CompW-1:0] in_dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [vcls_pkg::CompW-1:0] out_vel_x,
  output logic signed [vcls_pkg::CompW-1:0] out_vel_y,
  output logic signed [vcls_pkg::CompW-1:0] out_vel_z,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [vcls_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [vcls_pkg::LimW-1:0]         cfg_data
);
  import vcls_pkg::*;

  localparam int QCntW = $clog2(QDepth+1);

  logic [LimW-1:0] hl_r, vl_r;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r <= HorizLimitReset;
      vl_r <= VertLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgHorizLimit: hl_r <= cfg_data;
        CfgVertLimit:  vl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // output skid register
  logic ov_r;
  logic signed [CompW-1:0] ox_r, oy_r, oz_r;
  logic os_r;
  logic res_valid, res_sat;
  logic signed [CompW-1:0] res_x, res_y, res_z;
  logic adv;

  // the back chain moves while the output slot can take a result
  assign adv = !ov_r || !out_stall;

  // front only stops when its finished request cannot enter the fifo
  logic job_valid;
  job_t job, qd;
  logic q_valid;
  logic [QCntW-1:0] q_count;
  logic front_adv;

  assign front_adv = !(job_valid && (q_count == QCntW'(QDepth)));
  assign in_stall  = !front_adv;

  vcls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (front_adv),
    .in_valid  (in_valid),
    .in_dir_x  (in_dir_x),
    .in_dir_y  (in_dir_y),
    .in_dir_z  (in_dir_z),
    .hl        (hl_r),
    .vl        (vl_r),
    .job_valid (job_valid),
    .job       (job)
  );

  vcls_queue #(.Depth(QDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_adv && job_valid),
    .wr_data  (job),
    .rd_en    (adv && q_valid),
    .rd_valid (q_valid),
    .rd_data  (qd),
    .count    (q_count)
  );

  vcls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .job_valid (q_valid),
    .job       (qd),
    .res_valid (res_valid),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z),
    .res_sat   (res_sat)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= res_x;
      oy_r <= res_y;
      oz_r <= res_z;
      os_r <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= res_valid;
    end
  end

  assign out_valid     = ov_r;
  assign out_vel_x     = ox_r;
  assign out_vel_y     = oy_r;
  assign out_vel_z     = oz_r;
  assign out_saturated = os_r;

endmodule
